// ===== design/m68_alu_pkg.sv =====
`default_nettype none

package m68_alu_pkg;

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_AND   = 5'd2,
      OP_ASL   = 5'd3,
      OP_ASR   = 5'd4,
      OP_COM   = 5'd5,
      OP_LSR   = 5'd6,
      OP_NEG   = 5'd7,
      OP_OR    = 5'd8,
      OP_ROL   = 5'd9,
      OP_ROR   = 5'd10,
      OP_SUB   = 5'd11,
      OP_SUB16 = 5'd12,
      OP_SBC   = 5'd13,
      OP_TST   = 5'd14,
      OP_XOR   = 5'd15,
      OP_CLR   = 5'd16,
      OP_DAA   = 5'd17,
      OP_DEC   = 5'd18,
      OP_INC   = 5'd19
   } op_type;

   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_V = 1;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_H = 4;

   localparam logic [7:0] DAA_LOW_FIX  = 8'h06;
   localparam logic [7:0] DAA_HIGH_FIX = 8'h60;
   localparam logic [7:0] BYTE_MIN_NEG = 8'h80;
   localparam logic [7:0] BYTE_MAX_POS = 8'h7F;

   typedef struct packed {
      op_type      op;
      logic [15:0] a;
      logic [15:0] b;
      logic [4:0]  flags;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [4:0]  flags;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== design/m68_alu_core.sv =====
`default_nettype none

module m68_alu_core (
   input  m68_alu_pkg::alu_req_type req,
   output m68_alu_pkg::alu_rsp_type rsp
);
   import m68_alu_pkg::*;

   function automatic logic [4:0] nz_upd(input logic [4:0] f, input logic [7:0] r8);
      logic [4:0] g;
      g = f;
      g[FLAG_N] = r8[7];
      g[FLAG_Z] = (r8 == 8'h00);
      return g;
   endfunction

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        cin;
   logic        cin_add;
   logic        bin;
   logic [7:0]  sub_b;
   logic [8:0]  sum9;
   logic [4:0]  half5;
   logic [8:0]  diff9;
   logic [15:0] diff16;
   logic        lo_gt9;
   logic        hi_gt9;
   logic        hi_gt8;
   logic        high_fix;
   logic [7:0]  corr;
   logic [7:0]  r8;
   logic [4:0]  f;

   assign a8      = req.a[7:0];
   assign b8      = req.b[7:0];
   assign cin     = req.flags[FLAG_C];
   assign cin_add = (req.op == OP_ADC) ? cin : 1'b0;
   assign bin     = (req.op == OP_SBC) ? cin : 1'b0;
   assign sub_b   = (req.op == OP_TST) ? 8'h00 : b8;
   assign sum9    = {1'b0, a8} + {1'b0, b8} + {8'h00, cin_add};
   assign half5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, cin_add};
   assign diff9   = {1'b0, a8} - {1'b0, sub_b} - {8'h00, bin};
   assign diff16  = req.a - req.b;

   assign lo_gt9   = (a8[3:0] > 4'd9);
   assign hi_gt9   = (a8[7:4] > 4'd9);
   assign hi_gt8   = (a8[7:4] > 4'd8);
   assign high_fix = cin | hi_gt9 | (hi_gt8 & lo_gt9);
   assign corr     = ((req.flags[FLAG_H] | lo_gt9) ? DAA_LOW_FIX : 8'h00)
                   | (high_fix ? DAA_HIGH_FIX : 8'h00);

   always_comb begin
      f  = req.flags;
      r8 = 8'h00;
      rsp.result = 16'h0000;
      case (req.op)
         OP_ADD, OP_ADC: begin
            r8 = sum9[7:0];
            f = nz_upd(f, r8);
            f[FLAG_H] = half5[4];
            f[FLAG_C] = sum9[8];
            f[FLAG_V] = (a8[7] & b8[7] & ~r8[7]) | (~a8[7] & ~b8[7] & r8[7]);
         end
         OP_SUB, OP_SBC, OP_TST: begin
            r8 = diff9[7:0];
            f = nz_upd(f, r8);
            f[FLAG_C] = diff9[8];
            f[FLAG_V] = (a8[7] & ~sub_b[7] & ~r8[7]) | (~a8[7] & sub_b[7] & r8[7]);
         end
         OP_AND: begin
            r8 = a8 & b8;
            f = nz_upd(f, r8);
            f[FLAG_V] = 1'b0;
         end
         OP_OR: begin
            r8 = a8 | b8;
            f = nz_upd(f, r8);
            f[FLAG_V] = 1'b0;
         end
         OP_XOR: begin
            r8 = a8 ^ b8;
            f = nz_upd(f, r8);
            f[FLAG_V] = 1'b0;
         end
         OP_COM: begin
            r8 = ~a8;
            f = nz_upd(f, r8);
            f[FLAG_V] = 1'b0;
            f[FLAG_C] = 1'b1;
         end
         OP_ASL, OP_ROL: begin
            r8 = {a8[6:0], (req.op == OP_ROL) ? cin : 1'b0};
            f = nz_upd(f, r8);
            f[FLAG_C] = a8[7];
            f[FLAG_V] = r8[7] ^ a8[7];
         end
         OP_ASR, OP_LSR, OP_ROR: begin
            case (req.op)
               OP_ASR:  r8 = {a8[7], a8[7:1]};
               OP_ROR:  r8 = {cin, a8[7:1]};
               default: r8 = {1'b0, a8[7:1]};
            endcase
            f = nz_upd(f, r8);
            f[FLAG_C] = a8[0];
            f[FLAG_V] = r8[7] ^ a8[0];
         end
         OP_NEG: begin
            r8 = 8'h00 - a8;
            f = nz_upd(f, r8);
            f[FLAG_C] = (r8 != 8'h00);
            f[FLAG_V] = (r8 == BYTE_MIN_NEG);
         end
         OP_SUB16: begin
            f[FLAG_N] = diff16[15];
            f[FLAG_Z] = (diff16 == 16'h0000);
            f[FLAG_V] = (req.a[15] & ~req.b[15] & ~diff16[15])
                      | (~req.a[15] & req.b[15] & diff16[15]);
         end
         OP_CLR: begin
            f = 5'b00000;
            f[FLAG_H] = req.flags[FLAG_H];
            f[FLAG_Z] = 1'b1;
         end
         OP_DAA: begin
            r8 = a8 + corr;
            f = nz_upd(f, r8);
            f[FLAG_C] = high_fix;
         end
         OP_DEC: begin
            r8 = a8 - 8'h01;
            f = nz_upd(f, r8);
            f[FLAG_V] = (a8 == BYTE_MIN_NEG);
         end
         OP_INC: begin
            r8 = a8 + 8'h01;
            f = nz_upd(f, r8);
            f[FLAG_V] = (a8 == BYTE_MAX_POS);
         end
         default: begin
            r8 = 8'h00;
         end
      endcase
      rsp.result = (req.op == OP_SUB16) ? diff16 : {8'h00, r8};
      rsp.flags  = f;
   end

endmodule

`default_nettype wire

// ===== design/cpu8_alu_with_condition_codes_unit.sv =====
// 8-bit accumulator ALU (plus a 16-bit OP_SUB16) with H, N, Z, V, C condition
// codes. Each transaction carries an opcode, two operands and the incoming
// flags; one transaction returns the result and the updated flags. Throughput
// is one transaction per clock unless rsp_ready holds back results. The input
// register loads at acceptance, and the result register, which drives rsp_valid,
// loads from it when the output side is free, with one pass of ALU logic between.
// Flags an operation does not write pass through; unused opcodes return zero.
`default_nettype none

module cpu8_alu_with_condition_codes_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_type,
   input  wire logic [15:0] req_operand_a,
   input  wire logic [15:0] req_operand_b,
   input  wire logic [4:0]  req_flags_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_result,
   output logic [4:0]       rsp_flags_out
);
   import m68_alu_pkg::*;

   logic        stage_valid_ff;
   logic        stage_valid_in;
   alu_req_type stage_ff;
   alu_req_type stage_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   alu_rsp_type out_ff;
   alu_rsp_type core_rsp;
   logic        out_ready;
   logic        stage_move;
   logic        req_take;

   assign out_ready  = ~out_valid_ff | rsp_ready;
   assign stage_move = stage_valid_ff & out_ready;
   assign req_ready  = ~stage_valid_ff | out_ready;
   assign req_take   = req_valid & req_ready;

   assign stage_in.op    = op_type'(req_type);
   assign stage_in.a     = req_operand_a;
   assign stage_in.b     = req_operand_b;
   assign stage_in.flags = req_flags_in;

   assign stage_valid_in = req_take | (stage_valid_ff & ~out_ready);
   assign out_valid_in   = stage_move | (out_valid_ff & ~rsp_ready);

   m68_alu_core u_core (
      .req (stage_ff),
      .rsp (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
      if (stage_move) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = out_ff.result;
   assign rsp_flags_out = out_ff.flags;

endmodule

`default_nettype wire

// ===== verif/cpu8_alu_with_condition_codes_unit_tb.sv =====
`default_nettype none

module cpu8_alu_with_condition_codes_unit_tb;
   import m68_alu_pkg::*;

   localparam int DIR_ROWS     = 25;
   localparam int RAND_ITEMS   = 425;
   localparam int TAIL_ITEMS   = 50;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 1000;

   localparam logic [4:0] OP_UNUSED_LO = 5'd20;
   localparam logic [4:0] OP_UNUSED_HI = 5'd31;

   typedef struct packed {
      logic [4:0]  op;
      logic [15:0] a;
      logic [15:0] b;
      logic [4:0]  fl;
      logic        chk;
      logic [15:0] res;
      logic [4:0]  fo;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_type = '0;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic [4:0]  req_flags_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_result;
   logic [4:0]  rsp_flags_out;

   logic        tail_mode = 1'b0;
   int          mismatch_cnt = 0;
   int          accept_cnt = 0;
   int          idle_cycles = 0;
   stim_type    stim_q[$];
   alu_rsp_type want_q[$];
   alu_rsp_type want;

   logic [7:0] corner_bytes [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

   stim_type dir_tab [DIR_ROWS] = '{
      '{OP_CLR,       16'hFFFF, 16'hFFFF, 5'h1F, 1'b1, 16'h0000, 5'h14},
      '{OP_CLR,       16'h0000, 16'h0000, 5'h00, 1'b1, 16'h0000, 5'h04},
      '{OP_UNUSED_LO, 16'h1234, 16'h5678, 5'h15, 1'b1, 16'h0000, 5'h15},
      '{OP_UNUSED_HI, 16'hFFFF, 16'hFFFF, 5'h0A, 1'b1, 16'h0000, 5'h0A},
      '{OP_NEG,       16'h0080, 16'h0000, 5'h00, 1'b1, 16'h0080, 5'h0B},
      '{OP_INC,       16'h007F, 16'h0000, 5'h00, 1'b1, 16'h0080, 5'h0A},
      '{OP_DEC,       16'h0080, 16'h0000, 5'h00, 1'b1, 16'h007F, 5'h02},
      '{OP_ADD,       16'h00FF, 16'h0001, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_ADD,       16'h007F, 16'h0001, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_ADD,       16'hAB01, 16'hCD02, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_ADC,       16'h00FF, 16'h0000, 5'h01, 1'b0, 16'h0000, 5'h00},
      '{OP_AND,       16'hFFFF, 16'h00FF, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_ASL,       16'h0080, 16'h0000, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_ASR,       16'h0081, 16'h0000, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_COM,       16'h0000, 16'h0000, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_LSR,       16'h0001, 16'h0000, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_NEG,       16'h0000, 16'h0000, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_OR,        16'h0000, 16'h0000, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_ROL,       16'h0080, 16'h0000, 5'h01, 1'b0, 16'h0000, 5'h00},
      '{OP_ROR,       16'h0001, 16'h0000, 5'h01, 1'b0, 16'h0000, 5'h00},
      '{OP_SUB,       16'h0000, 16'h0001, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_SUB16,     16'h8000, 16'h0001, 5'h1F, 1'b0, 16'h0000, 5'h00},
      '{OP_SUB16,     16'h1234, 16'h1234, 5'h00, 1'b0, 16'h0000, 5'h00},
      '{OP_SBC,       16'h0080, 16'h007F, 5'h01, 1'b0, 16'h0000, 5'h00},
      '{OP_DAA,       16'h009A, 16'h0000, 5'h00, 1'b0, 16'h0000, 5'h00}
   };

   cpu8_alu_with_condition_codes_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_flags_in  (req_flags_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .rsp_flags_out (rsp_flags_out)
   );

   function automatic logic [4:0] set_nz(input logic [4:0] f, input logic [7:0] r);
      f[FLAG_N] = r[7];
      f[FLAG_Z] = (r == 8'h00);
      return f;
   endfunction

   function automatic logic carry_out(input logic x, input logic y, input logic s);
      return (x & y) | (y & ~s) | (~s & x);
   endfunction

   function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b,
                                       input logic cin, inout logic [4:0] f);
      logic [7:0] r;
      r = a + b + {7'd0, cin};
      f[FLAG_H] = carry_out(a[3], b[3], r[3]);
      f[FLAG_C] = carry_out(a[7], b[7], r[7]);
      f[FLAG_V] = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
      f = set_nz(f, r);
      return r;
   endfunction

   function automatic logic [7:0] sub8(input logic [7:0] a, input logic [7:0] b,
                                       input logic bin, inout logic [4:0] f);
      logic [7:0] r;
      r = a - b - {7'd0, bin};
      f[FLAG_V] = (a[7] & ~b[7] & ~r[7]) | (~a[7] & b[7] & r[7]);
      f[FLAG_C] = (~a[7] & b[7]) | (b[7] & r[7]) | (r[7] & ~a[7]);
      f = set_nz(f, r);
      return r;
   endfunction

   function automatic logic [4:0] shift_flags(input logic [4:0] f, input logic [7:0] r,
                                              input logic cout);
      f[FLAG_C] = cout;
      f = set_nz(f, r);
      f[FLAG_V] = r[7] ^ cout;
      return f;
   endfunction

   function automatic alu_rsp_type alu_predict(input stim_type s);
      logic [7:0]  a, b, r, corr;
      logic [15:0] r16;
      logic [4:0]  f;
      logic [3:0]  hi, lo;
      logic        cin, hfix;
      alu_rsp_type o;
      a   = s.a[7:0];
      b   = s.b[7:0];
      f   = s.fl;
      cin = s.fl[FLAG_C];
      r   = 8'h00;
      r16 = 16'h0000;
      case (s.op)
         OP_ADD:  r = add8(a, b, 1'b0, f);
         OP_ADC:  r = add8(a, b, cin, f);
         OP_AND: begin
            r = a & b;
            f = set_nz(f, r);
            f[FLAG_V] = 1'b0;
         end
         OP_ASL: begin
            r = {a[6:0], 1'b0};
            f = shift_flags(f, r, a[7]);
         end
         OP_ASR: begin
            r = {a[7], a[7:1]};
            f = shift_flags(f, r, a[0]);
         end
         OP_COM: begin
            r = ~a;
            f = set_nz(f, r);
            f[FLAG_V] = 1'b0;
            f[FLAG_C] = 1'b1;
         end
         OP_LSR: begin
            r = {1'b0, a[7:1]};
            f = shift_flags(f, r, a[0]);
         end
         OP_NEG: begin
            r = 8'h00 - a;
            f[FLAG_C] = (r != 8'h00);
            f[FLAG_V] = (r == BYTE_MIN_NEG);
            f = set_nz(f, r);
         end
         OP_OR: begin
            r = a | b;
            f = set_nz(f, r);
            f[FLAG_V] = 1'b0;
         end
         OP_ROL: begin
            r = {a[6:0], cin};
            f = shift_flags(f, r, a[7]);
         end
         OP_ROR: begin
            r = {cin, a[7:1]};
            f = shift_flags(f, r, a[0]);
         end
         OP_SUB:  r = sub8(a, b, 1'b0, f);
         OP_SUB16: begin
            r16 = s.a - s.b;
            f[FLAG_V] = (s.a[15] & ~s.b[15] & ~r16[15]) | (~s.a[15] & s.b[15] & r16[15]);
            f[FLAG_N] = r16[15];
            f[FLAG_Z] = (r16 == 16'h0000);
         end
         OP_SBC:  r = sub8(a, b, cin, f);
         OP_TST:  r = sub8(a, 8'h00, 1'b0, f);
         OP_XOR: begin
            r = a ^ b;
            f = set_nz(f, r);
            f[FLAG_V] = 1'b0;
         end
         OP_CLR: begin
            r = 8'h00;
            f[FLAG_N] = 1'b0;
            f[FLAG_Z] = 1'b1;
            f[FLAG_V] = 1'b0;
            f[FLAG_C] = 1'b0;
         end
         OP_DAA: begin
            hi   = a[7:4];
            lo   = a[3:0];
            corr = 8'h00;
            if (f[FLAG_H] || lo > 4'd9) begin
               corr = corr | DAA_LOW_FIX;
            end
            hfix = cin || (hi > 4'd9) || (hi > 4'd8 && lo > 4'd9);
            if (hfix) begin
               corr = corr | DAA_HIGH_FIX;
            end
            r = a + corr;
            f[FLAG_C] = hfix;
            f = set_nz(f, r);
         end
         OP_DEC: begin
            r = a - 8'h01;
            f = set_nz(f, r);
            f[FLAG_V] = (a == BYTE_MIN_NEG);
         end
         OP_INC: begin
            r = a + 8'h01;
            f = set_nz(f, r);
            f[FLAG_V] = (a == BYTE_MAX_POS);
         end
         default: r = 8'h00;
      endcase
      o.result = (s.op == OP_SUB16) ? r16 : {8'h00, r};
      o.flags  = f;
      return o;
   endfunction

   function automatic stim_type rand_item();
      stim_type s;
      s = '0;
      if ($urandom_range(0, 99) < 8) begin
         s.op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
         s.op = 5'($urandom_range(OP_ADD, OP_INC));
      end
      s.a = 16'($urandom);
      s.b = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         s.a[7:0] = corner_bytes[$urandom_range(0, 4)];
      end
      if ($urandom_range(0, 3) == 0) begin
         s.b[7:0] = corner_bytes[$urandom_range(0, 4)];
      end
      if (s.op == OP_SUB16 && $urandom_range(0, 4) == 0) begin
         s.b = s.a;
      end
      s.fl = 5'($urandom);
      return s;
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (want_q.size() == 0) begin
               $error("unexpected transaction: result %h flags_out %h",
                      rsp_result, rsp_flags_out);
               mismatch_cnt++;
            end else begin
               want = want_q.pop_front();
               if (rsp_result !== want.result) begin
                  $error("result: expected %h, actual %h", want.result, rsp_result);
                  mismatch_cnt++;
               end
               if (rsp_flags_out !== want.flags) begin
                  $error("flags_out: expected %h, actual %h", want.flags, rsp_flags_out);
                  mismatch_cnt++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (stim_q[accept_cnt].chk) begin
               want.result = stim_q[accept_cnt].res;
               want.flags  = stim_q[accept_cnt].fo;
            end else begin
               want = alu_predict(stim_q[accept_cnt]);
            end
            want_q.push_back(want);
            accept_cnt++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // random backpressure on the result side
   initial begin
      int len;
      repeat (5) @(posedge clock);
      forever begin
         if (tail_mode) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            len = $urandom_range(1, 60);
            repeat (len) @(posedge clock);
            if (!tail_mode && $urandom_range(0, 1) == 0) begin
               rsp_ready <= 1'b0;
               len = $urandom_range(1, 19);
               repeat (len) @(posedge clock);
            end
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("cpu8_alu_with_condition_codes_unit_tb: done, errors");
      $finish;
   end

   initial begin
      stim_type it;
      int       gap;
      bit       gappy;
      for (int i = 0; i < DIR_ROWS; i++) begin
         stim_q.push_back(dir_tab[i]);
      end
      repeat (RAND_ITEMS) stim_q.push_back(rand_item());
      gappy = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stim_q.size(); i++) begin
         if (i % 40 == 0) begin
            gappy = ($urandom_range(0, 2) != 0);
         end
         if (i >= stim_q.size() - TAIL_ITEMS) begin
            tail_mode <= 1'b1;
            gappy = 1'b0;
         end
         gap = 0;
         if (gappy && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         it = stim_q[i];
         req_valid     <= 1'b1;
         req_type      <= it.op;
         req_operand_a <= it.a;
         req_operand_b <= it.b;
         req_flags_in  <= it.fl;
         // hold until the transaction is taken
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      while (want_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && want_q.size() == 0) begin
         $display("cpu8_alu_with_condition_codes_unit_tb: done, clean");
      end else begin
         $display("cpu8_alu_with_condition_codes_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/m68_alu_pkg.sv
design/m68_alu_core.sv
design/cpu8_alu_with_condition_codes_unit.sv
verif/cpu8_alu_with_condition_codes_unit_tb.sv
